### rtl/core/balist_pkg.sv
// Shared constants and types for the bounded array list engine.
// No dependencies; imported by bounded_array_list_engine.
package balist_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = 6;   // entry index width
  localparam int CW       = 7;   // count width, holds CAPACITY itself

  typedef logic signed [31:0] word_t;

  // request codes
  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_SORT = 3'd1,
    OP_APPEND   = 3'd2,
    OP_RM_HEAD  = 3'd3,
    OP_RM_VAL   = 3'd4,
    OP_RM_TAIL  = 3'd5,
    OP_FIND     = 3'd6,
    OP_READ     = 3'd7
  } kind_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_RDWAIT = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

endpackage

### rtl/core/bounded_array_list_engine.sv
// Bounded array list engine: one entry memory walked by a small sequencer.
// Depends on balist_pkg.
//
// Usage: a request word (kind, value, index) enters on in_valid/in_stall and
// is taken when in_valid is high and in_stall low. The engine works on one
// request at a time; in_stall stays high from the accepting edge until the
// result is loaded into the output register. One result word per request
// leaves on out_valid/out_stall and is held while out_stall is high; a new
// request may be taken while that result still waits.
// out_valid rises as the result is loaded, in the same cycle that the engine
// returns to IDLE and can take the next request. Remove tail, insert when
// full, remove when empty and read past count go straight to DONE; a read
// waits in RDWAIT; append writes in INSERT; find scans; remove head shifts
// down; insert head shifts up, then inserts; remove value scans, then shifts
// down; insert sorted scans, shifts up, then inserts.
// The entry memory has one read and one write port: a search
// reads one entry a cycle, and a shift moves one entry a cycle (read, then
// write the next cycle, overlapped). Reset empties the list at once; entry
// contents are not cleared and no clearing pass runs. A stalled receiver holds
// the result and the engine finishes its next request, then waits in DONE.
module bounded_array_list_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  balist_pkg::kind_t    kind,
  input  balist_pkg::word_t    value,
  input  logic [5:0]           index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 success,
  output logic [5:0]           position,
  output balist_pkg::word_t    data,
  output logic [6:0]           count,
  output logic                 is_empty,
  output logic                 is_full
);
  import balist_pkg::*;

  state_t         state;
  kind_t          op;
  word_t          val;
  logic [CW-1:0]  ent_count;

  // entry memory
  word_t          mem [CAPACITY];
  word_t          rd_data;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  wr_addr;
  word_t          wr_data;

  // search walker
  logic [CW-1:0]  scan_ptr;
  logic [AW-1:0]  cmp_ptr;
  logic           cmp_vld;
  logic           hit;
  logic           scan_end;

  // shift walker
  logic           shift_up;
  logic [AW-1:0]  src;
  logic [CW-1:0]  moves_left;
  logic           pend_vld;
  logic [AW-1:0]  pend_addr;

  // result being built
  logic           res_ok;
  logic [AW-1:0]  res_pos;
  word_t          res_data;

  logic           accept;
  logic           full;
  logic           empty;
  logic [AW-1:0]  sort_pos;
  logic           out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign full     = (ent_count == CW'(CAPACITY));
  assign empty    = (ent_count == '0);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // compare the entry read last cycle
  always_comb begin
    if (op == OP_INS_SORT) begin
      hit = cmp_vld && !(rd_data < val);
    end else begin
      hit = cmp_vld && (rd_data == val);
    end
    scan_end = hit || (scan_ptr >= ent_count);
    sort_pos = hit ? cmp_ptr : ent_count[AW-1:0];
  end

  // select memory addresses
  always_comb begin
    case (state)
      ST_SCAN:  rd_addr = scan_ptr[AW-1:0];
      ST_SHIFT: rd_addr = src;
      default:  rd_addr = index;
    endcase
    we      = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    if (state == ST_SHIFT && pend_vld) begin
      we = 1'b1;
    end else if (state == ST_INSERT) begin
      we      = 1'b1;
      wr_addr = res_pos;
      wr_data = val;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ent_count <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      pend_vld  <= 1'b0;
    end else begin
      // load a new output word or drop the taken one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op       <= kind;
            val      <= value;
            res_ok   <= 1'b0;
            res_pos  <= '0;
            res_data <= '0;
            scan_ptr <= '0;
            cmp_vld  <= 1'b0;
            pend_vld <= 1'b0;
            case (kind)
              OP_INS_HEAD: begin
                if (full) begin
                  state <= ST_DONE;
                end else begin
                  shift_up   <= 1'b1;
                  moves_left <= ent_count;
                  src        <= AW'(ent_count - CW'(1));
                  state      <= ST_SHIFT;
                end
              end
              OP_APPEND: begin
                res_pos <= ent_count[AW-1:0];
                state   <= full ? ST_DONE : ST_INSERT;
              end
              OP_INS_SORT: begin
                state <= full ? ST_DONE : ST_SCAN;
              end
              OP_RM_HEAD: begin
                if (empty) begin
                  state <= ST_DONE;
                end else begin
                  res_ok     <= 1'b1;
                  shift_up   <= 1'b0;
                  moves_left <= ent_count - CW'(1);
                  src        <= AW'(1);
                  state      <= ST_SHIFT;
                end
              end
              OP_RM_TAIL: begin
                if (!empty) begin
                  res_ok    <= 1'b1;
                  res_pos   <= AW'(ent_count - CW'(1));
                  ent_count <= ent_count - CW'(1);
                end
                state <= ST_DONE;
              end
              OP_READ: begin
                res_pos <= index;
                state   <= ({1'b0, index} < ent_count) ? ST_RDWAIT : ST_DONE;
              end
              default: begin
                state <= ST_SCAN;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_end) begin
            cmp_vld <= 1'b0;
            case (op)
              OP_INS_SORT: begin
                res_pos    <= sort_pos;
                shift_up   <= 1'b1;
                moves_left <= ent_count - {1'b0, sort_pos};
                src        <= AW'(ent_count - CW'(1));
                state      <= ST_SHIFT;
              end
              OP_RM_VAL: begin
                if (hit) begin
                  res_ok     <= 1'b1;
                  res_pos    <= cmp_ptr;
                  shift_up   <= 1'b0;
                  moves_left <= ent_count - CW'(1) - {1'b0, cmp_ptr};
                  src        <= cmp_ptr + AW'(1);
                  state      <= ST_SHIFT;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                res_ok  <= hit;
                res_pos <= hit ? cmp_ptr : '0;
                state   <= ST_DONE;
              end
            endcase
          end else begin
            // issue the next entry read, compare it next cycle
            cmp_vld  <= 1'b1;
            cmp_ptr  <= scan_ptr[AW-1:0];
            scan_ptr <= scan_ptr + CW'(1);
          end
        end

        ST_RDWAIT: begin
          res_ok   <= 1'b1;
          res_data <= rd_data;
          state    <= ST_DONE;
        end

        ST_SHIFT: begin
          if (moves_left != '0) begin
            pend_vld   <= 1'b1;
            pend_addr  <= shift_up ? src + AW'(1) : src - AW'(1);
            src        <= shift_up ? src - AW'(1) : src + AW'(1);
            moves_left <= moves_left - CW'(1);
          end else begin
            pend_vld <= 1'b0;
            if (!pend_vld) begin
              if (shift_up) begin
                state <= ST_INSERT;
              end else begin
                ent_count <= ent_count - CW'(1);
                state     <= ST_DONE;
              end
            end
          end
        end

        ST_INSERT: begin
          res_ok    <= 1'b1;
          ent_count <= ent_count + CW'(1);
          state     <= ST_DONE;
        end

        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            success   <= res_ok;
            position  <= res_ok ? res_pos : '0;
            data      <= res_data;
            count     <= ent_count;
            is_empty  <= empty;
            is_full   <= full;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ent_count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_SHIFT || state == ST_INSERT))
    else $error("memory write outside shift or insert");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ent_count != $past(ent_count)) |->
      (ent_count == $past(ent_count) + CW'(1) || ent_count + CW'(1) == $past(ent_count)))
    else $error("entry count moved by more than one");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> moves_left <= ent_count)
    else $error("shift walk longer than the list");
`endif

endmodule
